// ----- design/tag_value_text_encoder_assert.svh -----
// Assertion macros shared by the tag=value text encoder RTL.
`ifndef TAG_VALUE_TEXT_ENCODER_ASSERT_SVH
`define TAG_VALUE_TEXT_ENCODER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define TVTE_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define TVTE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- design/tvte_pkg.sv -----
// Shared types and constants for the tag=value text encoder.
package tvte_pkg;

	// Field widths
	localparam int OP_W    = 3;
	localparam int TAG_W   = 31;
	localparam int VAL_W   = 64;
	localparam int CHAR_W  = 8;

	// Configuration port
	localparam int ADDR_W  = 4;
	localparam int DATA_W  = 32;

	// Decimal conversion: 20 digits cover a 64-bit magnitude
	localparam int DIGITS  = 20;
	localparam int PTR_W   = $clog2(DIGITS);
	localparam int STEP_W  = $clog2(VAL_W + 1);

	// Output byte count per item
	localparam int MAX_BYTES = 32;
	localparam int CNT_W     = $clog2(MAX_BYTES);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_BYTES - 1);

	// Event codes
	typedef enum logic [OP_W-1:0] {
		OP_OPEN  = 3'd0,
		OP_CLOSE = 3'd1,
		OP_BOOL  = 3'd2,
		OP_INT   = 3'd3,
		OP_GROUP = 3'd4,
		OP_ELEM  = 3'd5,
		OP_EMPTY = 3'd6
	} op_t;

	// Register indexes
	typedef enum logic [1:0] {
		REG_OPEN  = 2'd0,
		REG_CLOSE = 2'd1,
		REG_YES   = 2'd2,
		REG_NO    = 2'd3
	} reg_idx_t;

	// Fixed ASCII bytes
	localparam logic [CHAR_W-1:0] CH_BAR   = 8'h7C;
	localparam logic [CHAR_W-1:0] CH_EQ    = 8'h3D;
	localparam logic [CHAR_W-1:0] CH_QUOTE = 8'h22;
	localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
	localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;

	// Reset values of the configurable bytes
	localparam logic [CHAR_W-1:0] RST_OPEN  = 8'd91;
	localparam logic [CHAR_W-1:0] RST_CLOSE = 8'd93;
	localparam logic [CHAR_W-1:0] RST_YES   = 8'd89;
	localparam logic [CHAR_W-1:0] RST_NO    = 8'd78;

	// Configured bytes handed to the sequencer
	typedef struct packed {
		logic [CHAR_W-1:0] open_ch;
		logic [CHAR_W-1:0] close_ch;
		logic [CHAR_W-1:0] yes_ch;
		logic [CHAR_W-1:0] no_ch;
	} chars_t;

endpackage

// ----- design/tvte_cfg.sv -----
// Configuration register file behind the APB-style port.
module tvte_cfg (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [tvte_pkg::ADDR_W-1:0]  paddr,
	input  logic [tvte_pkg::DATA_W-1:0]  pwdata,
	output logic [tvte_pkg::DATA_W-1:0]  prdata,
	output logic                         pready,
	output tvte_pkg::chars_t             chars
);
	import tvte_pkg::*;

	reg_idx_t idx;
	logic     wr_en;
	chars_t   chars_q;

	assign idx    = reg_idx_t'(paddr[3:2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign chars  = chars_q;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chars_q.open_ch  <= RST_OPEN;
			chars_q.close_ch <= RST_CLOSE;
			chars_q.yes_ch   <= RST_YES;
			chars_q.no_ch    <= RST_NO;
		end else if (wr_en) begin
			case (idx)
				REG_OPEN:  chars_q.open_ch  <= pwdata[CHAR_W-1:0];
				REG_CLOSE: chars_q.close_ch <= pwdata[CHAR_W-1:0];
				REG_YES:   chars_q.yes_ch   <= pwdata[CHAR_W-1:0];
				REG_NO:    chars_q.no_ch    <= pwdata[CHAR_W-1:0];
				default:   ;
			endcase
		end
	end

	// Read mux
	always_comb begin
		prdata = '0;
		case (idx)
			REG_OPEN:  prdata[CHAR_W-1:0] = chars_q.open_ch;
			REG_CLOSE: prdata[CHAR_W-1:0] = chars_q.close_ch;
			REG_YES:   prdata[CHAR_W-1:0] = chars_q.yes_ch;
			REG_NO:    prdata[CHAR_W-1:0] = chars_q.no_ch;
			default:   prdata = '0;
		endcase
	end

endmodule

// ----- design/tvte_bcd.sv -----
// Shared binary-to-decimal unit: shift-and-add-3, one bit per cycle.
module tvte_bcd (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  logic                                         start,
	input  logic [tvte_pkg::VAL_W-1:0]                   bin,
	output logic                                         busy,
	output logic [tvte_pkg::DIGITS-1:0][3:0]             digits
);
	import tvte_pkg::*;

	logic [VAL_W-1:0]         sh_q;
	logic [DIGITS-1:0][3:0]   bcd_q;
	logic [STEP_W-1:0]        step_q;
	logic [DIGITS-1:0][3:0]   adj;

	assign busy   = (step_q != '0);
	assign digits = bcd_q;

	// Add 3 to every digit of 5 or more before the shift
	always_comb begin
		for (int i = 0; i < DIGITS; i++) begin
			adj[i] = (bcd_q[i] >= 4'd5) ? (bcd_q[i] + 4'd3) : bcd_q[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (start) begin
			step_q <= STEP_W'(VAL_W);
		end else if (busy) begin
			step_q <= step_q - 1'b1;
		end
	end

	// Shift register pair, payload only
	always_ff @(posedge clk) begin
		if (start) begin
			sh_q  <= bin;
			bcd_q <= '0;
		end else if (busy) begin
			{bcd_q, sh_q} <= {adj[DIGITS-1:0], sh_q} << 1;
		end
	end

endmodule

// ----- design/tag_value_text_encoder.sv -----
// An open or close goes from the accept to S_LEAD, which loads its byte, and then back to
// S_IDLE, where the next item is taken. Each decimal number (tag or value) costs one pass
// of the shared 64-step binary-to-decimal unit, then a leading-zero skip and digit sends.
// Items are taken only in S_IDLE, so each item is finished before the next is accepted.
// Output stalls hold the sequencer. Reset clears control and flags, restores the chars.
module tag_value_text_encoder (
	input  logic                          clk,
	input  logic                          arst_n,
	// Item channel
	input  logic                          item_valid,
	output logic                          item_stall,
	input  logic [tvte_pkg::OP_W-1:0]     op,
	input  logic [tvte_pkg::TAG_W-1:0]    attr_number,
	input  logic signed [tvte_pkg::VAL_W-1:0] value,
	// Byte channel
	output logic                          byte_valid,
	input  logic                          byte_stall,
	output logic [tvte_pkg::CHAR_W-1:0]   out_byte,
	output logic                          last,
	// Configuration port
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [tvte_pkg::ADDR_W-1:0]   paddr,
	input  logic [tvte_pkg::DATA_W-1:0]   pwdata,
	output logic [tvte_pkg::DATA_W-1:0]   prdata,
	output logic                          pready
);
	import tvte_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_LEAD,
		S_SIGN,
		S_CONV,
		S_SKIP,
		S_DIGIT,
		S_EQ,
		S_TAIL
	} state_t;

	state_t                 state_q, nxt, nxt_eff;
	op_t                    op_q;
	logic [TAG_W-1:0]       tag_q;
	logic [VAL_W-1:0]       mag_q;
	logic                   neg_q, bit0_q;
	logic                   pre_q, first_q;
	logic                   preceded_q, first_elem_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [PTR_W-1:0]       ptr_q;
	logic                   phase_q;
	logic                   out_valid_q, last_q;
	logic [CHAR_W-1:0]      out_byte_q;

	chars_t                 chars;
	logic                   conv_busy, conv_start;
	logic [VAL_W-1:0]       conv_src;
	logic [DIGITS-1:0][3:0] digits;
	logic [3:0]             cur_digit;

	logic                   push, push_fin, push_last, can_push, adv, load_out;
	logic [CHAR_W-1:0]      push_byte;

	tvte_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.chars   (chars)
	);

	tvte_bcd u_bcd (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (conv_start),
		.bin    (conv_src),
		.busy   (conv_busy),
		.digits (digits)
	);

	assign item_stall = (state_q != S_IDLE);
	assign byte_valid = out_valid_q;
	assign out_byte   = out_byte_q;
	assign last       = last_q;

	assign cur_digit = digits[ptr_q];
	assign conv_src  = (state_q == S_SIGN) ? mag_q : {{(VAL_W-TAG_W){1'b0}}, tag_q};

	// Sequencer: byte to send and next step
	always_comb begin
		push      = 1'b0;
		push_byte = CH_BAR;
		push_fin  = 1'b0;
		nxt       = state_q;
		case (state_q)
			S_IDLE: nxt = S_IDLE;
			S_LEAD: begin
				case (op_q)
					OP_OPEN: begin
						push = 1'b1; push_byte = chars.open_ch; push_fin = 1'b1;
						nxt = S_IDLE;
					end
					OP_CLOSE: begin
						push = 1'b1; push_byte = chars.close_ch; push_fin = 1'b1;
						nxt = S_IDLE;
					end
					OP_ELEM: begin
						push = !first_q;
						nxt  = S_SIGN;
					end
					OP_BOOL, OP_INT, OP_GROUP, OP_EMPTY: begin
						push = pre_q;
						nxt  = S_CONV;
					end
					default: nxt = S_IDLE;
				endcase
			end
			S_SIGN: begin
				push = neg_q; push_byte = CH_MINUS;
				nxt  = S_CONV;
			end
			S_CONV: if (!conv_busy) nxt = S_SKIP;
			S_SKIP: begin
				nxt = (cur_digit == 4'd0 && ptr_q != '0) ? S_SKIP : S_DIGIT;
			end
			S_DIGIT: begin
				push      = 1'b1;
				push_byte = CH_ZERO | {4'b0, cur_digit};
				push_fin  = (ptr_q == '0) && phase_q;
				if (ptr_q == '0) nxt = phase_q ? S_IDLE : S_EQ;
				else             nxt = S_DIGIT;
			end
			S_EQ: begin
				push = 1'b1; push_byte = CH_EQ;
				nxt  = S_TAIL;
			end
			S_TAIL: begin
				case (op_q)
					OP_BOOL: begin
						push = 1'b1; push_fin = 1'b1;
						push_byte = bit0_q ? chars.yes_ch : chars.no_ch;
						nxt = S_IDLE;
					end
					OP_INT: nxt = S_SIGN;
					OP_GROUP: begin
						push = 1'b1; push_byte = chars.open_ch; push_fin = 1'b1;
						nxt = S_IDLE;
					end
					OP_EMPTY: begin
						push = 1'b1; push_byte = CH_QUOTE; push_fin = 1'b1;
						nxt = S_IDLE;
					end
					default: nxt = S_IDLE;
				endcase
			end
			default: nxt = S_IDLE;
		endcase

		// The 32nd byte ends the item; anything after it is dropped
		can_push   = !out_valid_q || !byte_stall;
		adv        = !push || can_push;
		load_out   = push && can_push;
		push_last  = push && (push_fin || cnt_q == CNT_MAX);
		nxt_eff    = push_last ? S_IDLE : nxt;
		conv_start = adv && (state_q != S_CONV) && (nxt_eff == S_CONV);
	end

	// State, item registers and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			preceded_q   <= 1'b0;
			first_elem_q <= 1'b1;
			out_valid_q  <= 1'b0;
			last_q       <= 1'b0;
			cnt_q        <= '0;
			ptr_q        <= '0;
			phase_q      <= 1'b0;
			op_q         <= OP_OPEN;
			pre_q        <= 1'b0;
			first_q      <= 1'b1;
		end else begin
			// Output beat register
			if (load_out) begin
				out_valid_q <= 1'b1;
				last_q      <= push_last;
				cnt_q       <= cnt_q + 1'b1;
			end else if (!byte_stall) begin
				out_valid_q <= 1'b0;
			end

			if (state_q == S_IDLE) begin
				if (item_valid) begin
					op_q    <= op_t'(op);
					pre_q   <= preceded_q;
					first_q <= first_elem_q;
					cnt_q   <= '0;
					phase_q <= 1'b0;
					state_q <= S_LEAD;
					// Flag updates are fixed by the event alone
					case (op_t'(op))
						OP_OPEN: begin
							preceded_q <= 1'b0; first_elem_q <= 1'b1;
						end
						OP_CLOSE: begin
							preceded_q <= 1'b1; first_elem_q <= 1'b1;
						end
						OP_BOOL, OP_INT, OP_EMPTY: preceded_q <= 1'b1;
						OP_GROUP: begin
							preceded_q <= 1'b0; first_elem_q <= 1'b1;
						end
						OP_ELEM: first_elem_q <= 1'b0;
						default: state_q <= S_IDLE;
					endcase
				end
			end else if (adv) begin
				state_q <= nxt_eff;
				if (state_q == S_SIGN) phase_q <= 1'b1;
				if (state_q == S_CONV && nxt == S_SKIP) ptr_q <= PTR_W'(DIGITS - 1);
				if (state_q == S_SKIP && nxt == S_SKIP) ptr_q <= ptr_q - 1'b1;
				if (state_q == S_DIGIT && ptr_q != '0) ptr_q <= ptr_q - 1'b1;
			end
		end
	end

	// Item payload, no reset
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && item_valid) begin
			tag_q  <= attr_number;
			neg_q  <= value[VAL_W-1];
			mag_q  <= value[VAL_W-1] ? (~value + 1'b1) : value;
			bit0_q <= value[0];
		end
	end

	// Payload register for the output beat
	always_ff @(posedge clk) begin
		if (load_out) out_byte_q <= push_byte;
	end

	`include "tag_value_text_encoder_assert.svh"

	`TVTE_ASSERT_IMP(a_skip_after_conv, state_q == S_SKIP, !conv_busy, "digits read while converting")
	`TVTE_ASSERT_NEXT(a_cap_ends_item, load_out && cnt_q == CNT_MAX, state_q == S_IDLE && last, "byte cap did not end item")
	`TVTE_ASSERT_IMP(a_ptr_range, state_q == S_DIGIT || state_q == S_SKIP, ptr_q < PTR_W'(DIGITS), "digit pointer out of range")
	`TVTE_ASSERT_NEXT(a_last_to_idle, load_out && push_last, state_q == S_IDLE, "item continued after last beat")

endmodule

// ----- tb/sv/testbench.sv -----
// Self-checking testbench for the tag=value text encoder: predicted bytes checked beat by beat.
`timescale 1ns / 1ps

module testbench;
	import tvte_pkg::*;

	localparam logic [OP_W-1:0]  OP_UNUSED     = 3'd7;  // no event, block ignores it
	localparam int               SETTLE_CYCLES = 200;
	localparam int               HOLD_CYCLES   = 400;
	localparam int               PHASE_ITEMS   = 96;
	localparam logic [VAL_W-1:0] VAL_MIN       = {1'b1, {(VAL_W-1){1'b0}}};
	localparam logic [VAL_W-1:0] VAL_MAX       = {1'b0, {(VAL_W-1){1'b1}}};
	localparam logic [TAG_W-1:0] TAG_MAX       = '1;

	typedef struct packed {
		logic [CHAR_W-1:0] ch;
		logic              fin;
	} text_beat_t;

	// Predicts the text bytes of each event and checks the byte stream against them
	class tag_text_board;
		logic [CHAR_W-1:0] chars [4];
		bit                preceded;
		bit                first_elem;
		logic [CHAR_W-1:0] line [$];
		text_beat_t        pending [$];
		int                errors;

		function new();
			chars[REG_OPEN]  = RST_OPEN;
			chars[REG_CLOSE] = RST_CLOSE;
			chars[REG_YES]   = RST_YES;
			chars[REG_NO]    = RST_NO;
			preceded   = 1'b0;
			first_elem = 1'b1;
			errors     = 0;
		endfunction

		function void put_byte(logic [CHAR_W-1:0] b);
			if (line.size() < MAX_BYTES) begin
				line.push_back(b);
			end
		endfunction

		// Unsigned decimal, no leading zeros
		function void put_dec(logic [VAL_W-1:0] mag);
			logic [CHAR_W-1:0] digs [DIGITS];
			int n;
			n = 0;
			if (mag == '0) begin
				put_byte(CH_ZERO);
				return;
			end
			while (mag != '0) begin
				digs[n] = CH_ZERO + CHAR_W'(mag % 10);
				n++;
				mag = mag / 10;
			end
			for (int i = n - 1; i >= 0; i--) begin
				put_byte(digs[i]);
			end
		endfunction

		function void put_sgn(logic [VAL_W-1:0] raw);
			if (raw[VAL_W-1]) begin
				put_byte(CH_MINUS);
				put_dec('0 - raw);
			end else begin
				put_dec(raw);
			end
		endfunction

		function void put_head(logic [TAG_W-1:0] tag);
			if (preceded) begin
				put_byte(CH_BAR);
			end
			preceded = 1'b1;
			put_dec(VAL_W'(tag));
			put_byte(CH_EQ);
		endfunction

		// Accepted event: queue the bytes it should produce
		function void note_event(logic [OP_W-1:0] code, logic [TAG_W-1:0] tag,
				logic [VAL_W-1:0] val);
			text_beat_t beat;
			line.delete();
			case (code)
				OP_OPEN: begin
					put_byte(chars[REG_OPEN]);
					preceded   = 1'b0;
					first_elem = 1'b1;
				end
				OP_CLOSE: begin
					put_byte(chars[REG_CLOSE]);
					preceded   = 1'b1;
					first_elem = 1'b1;
				end
				OP_BOOL: begin
					put_head(tag);
					put_byte(val[0] ? chars[REG_YES] : chars[REG_NO]);
				end
				OP_INT: begin
					put_head(tag);
					put_sgn(val);
				end
				OP_GROUP: begin
					put_head(tag);
					put_byte(chars[REG_OPEN]);
					preceded   = 1'b0;
					first_elem = 1'b1;
				end
				OP_ELEM: begin
					if (!first_elem) begin
						put_byte(CH_BAR);
					end
					first_elem = 1'b0;
					put_sgn(val);
				end
				OP_EMPTY: begin
					put_head(tag);
					put_byte(CH_QUOTE);
				end
				default: begin
				end
			endcase
			foreach (line[k]) begin
				beat.ch  = line[k];
				beat.fin = (k == line.size() - 1);
				pending.push_back(beat);
			end
		endfunction

		// Accepted output beat: compare with the oldest pending byte
		function void check_byte(logic [CHAR_W-1:0] ch, logic fin);
			text_beat_t want;
			if (pending.size() == 0) begin
				if (errors < 10) begin
					$display("%0t: unexpected byte 8'h%02h last=%0b", $realtime, ch, fin);
				end
				errors++;
				return;
			end
			want = pending.pop_front();
			if (want.ch !== ch || want.fin !== fin) begin
				if (errors < 10) begin
					$display("%0t: byte mismatch: expected 8'h%02h last=%0b, got 8'h%02h last=%0b",
						$realtime, want.ch, want.fin, ch, fin);
				end
				errors++;
			end
		endfunction
	endclass

	logic                     clk         = 1'b0;
	logic                     arst_n      = 1'b0;
	logic                     item_valid  = 1'b0;
	logic                     item_stall;
	logic [OP_W-1:0]          op          = '0;
	logic [TAG_W-1:0]         attr_number = '0;
	logic signed [VAL_W-1:0]  value       = '0;
	logic                     byte_valid;
	logic                     byte_stall  = 1'b0;
	logic [CHAR_W-1:0]        out_byte;
	logic                     last;
	logic                     psel        = 1'b0;
	logic                     penable     = 1'b0;
	logic                     pwrite      = 1'b0;
	logic [ADDR_W-1:0]        paddr       = '0;
	logic [DATA_W-1:0]        pwdata      = '0;
	logic [DATA_W-1:0]        prdata;
	logic                     pready;

	tag_text_board board = new();

	int send_idle  = 0;
	int stall_pct  = 0;
	int hold_left  = 0;
	int items_sent = 0;

	tag_value_text_encoder dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.op          (op),
		.attr_number (attr_number),
		.value       (value),
		.byte_valid  (byte_valid),
		.byte_stall  (byte_stall),
		.out_byte    (out_byte),
		.last        (last),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready)
	);

	// 12 ns clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Run limit
	initial begin
		#15ms;
		$display("Regression FAIL");
		$finish;
	end

	// Output monitor: check every accepted beat
	always @(posedge clk) begin
		if (arst_n && byte_valid && !byte_stall) begin
			board.check_byte(out_byte, last);
		end
	end

	// Receiver stall: random, or a long hold-off when requested
	initial begin
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				byte_stall <= 1'b1;
				hold_left--;
			end else begin
				byte_stall <= ($urandom_range(99) < stall_pct);
			end
		end
	end

	task automatic reg_write(reg_idx_t idx, logic [CHAR_W-1:0] v);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= DATA_W'(v);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		board.chars[idx] = v;
	endtask

	task automatic write_chars(logic [CHAR_W-1:0] o, logic [CHAR_W-1:0] c,
			logic [CHAR_W-1:0] y, logic [CHAR_W-1:0] n);
		reg_write(REG_OPEN, o);
		reg_write(REG_CLOSE, c);
		reg_write(REG_YES, y);
		reg_write(REG_NO, n);
	endtask

	// Offer one event, with random idle cycles before it
	task automatic send_item(logic [OP_W-1:0] code, logic [TAG_W-1:0] tag,
			logic [VAL_W-1:0] val);
		while ($urandom_range(99) < send_idle) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid  <= 1'b1;
		op          <= code;
		attr_number <= tag;
		value       <= val;
		do @(posedge clk); while (item_stall);
		board.note_event(code, tag, val);
		if (code != OP_UNUSED) begin
			items_sent++;
		end
	endtask

	// Stop offering, wait for every pending byte, then let the block settle
	task automatic wait_text_drained(int settle);
		item_valid <= 1'b0;
		do @(posedge clk); while (board.pending.size() != 0);
		repeat (settle) @(posedge clk);
	endtask

	function automatic logic [VAL_W-1:0] pick_value();
		logic [VAL_W-1:0] v;
		v = {$urandom, $urandom};
		case ($urandom_range(5))
			0: v = VAL_W'($urandom_range(20));
			1: v = '0 - VAL_W'($urandom_range(20));
			2: begin
			end
			3: v = v >> $urandom_range(63);
			4: v = '0 - (v >> $urandom_range(63));
			default: begin
				case ($urandom_range(4))
					0: v = VAL_MIN;
					1: v = VAL_MAX;
					2: v = '1;
					3: v = '0;
					default: v = VAL_W'(1);
				endcase
			end
		endcase
		return v;
	endfunction

	function automatic logic [TAG_W-1:0] pick_tag();
		logic [TAG_W-1:0] t;
		t = TAG_W'($urandom);
		case ($urandom_range(3))
			0: t = TAG_W'($urandom_range(99));
			1: begin
			end
			2: t = t >> $urandom_range(30);
			default: t = $urandom_range(1) ? TAG_MAX : '0;
		endcase
		return t;
	endfunction

	// One well-formed message: a group with attributes, arrays and nested groups
	task automatic send_message();
		int n_attr;
		n_attr = $urandom_range(1, 5);
		send_item(OP_OPEN, pick_tag(), pick_value());
		repeat (n_attr) begin
			case ($urandom_range(4))
				0: send_item(OP_BOOL, pick_tag(), pick_value());
				1: send_item(OP_INT, pick_tag(), pick_value());
				2: send_item(OP_EMPTY, pick_tag(), pick_value());
				3: begin
					send_item(OP_GROUP, pick_tag(), pick_value());
					repeat ($urandom_range(1, 4)) send_item(OP_ELEM, pick_tag(), pick_value());
					send_item(OP_CLOSE, pick_tag(), pick_value());
				end
				default: begin
					send_item(OP_GROUP, pick_tag(), pick_value());
					send_item(OP_BOOL, pick_tag(), pick_value());
					send_item(OP_INT, pick_tag(), pick_value());
					send_item(OP_CLOSE, pick_tag(), pick_value());
				end
			endcase
		end
		send_item(OP_CLOSE, pick_tag(), pick_value());
	endtask

	// Mostly messages, some loose events including the unused code
	task automatic run_random(int target);
		while (items_sent < target) begin
			if ($urandom_range(3) == 0) begin
				send_item(OP_W'($urandom_range(7)), pick_tag(), pick_value());
			end else begin
				send_message();
			end
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed events with reset characters
		send_item(OP_OPEN,   '0,        '0);
		send_item(OP_BOOL,   '0,        VAL_W'(1));
		send_item(OP_BOOL,   TAG_MAX,   '0);
		send_item(OP_INT,    TAG_W'(7), '0);
		send_item(OP_INT,    TAG_W'(12345), VAL_MAX);
		send_item(OP_INT,    TAG_MAX,   VAL_MIN);   // longest line, 32 bytes
		send_item(OP_INT,    TAG_W'(1), '1);
		send_item(OP_EMPTY,  TAG_W'(3), '0);
		send_item(OP_GROUP,  TAG_W'(4), '0);
		send_item(OP_ELEM,   '0,        VAL_MIN);
		send_item(OP_ELEM,   '0,        VAL_MAX);
		send_item(OP_ELEM,   '0,        '0);
		send_item(OP_CLOSE,  '0,        '0);
		send_item(OP_ELEM,   '0,        VAL_W'(5)); // first element again after close
		send_item(OP_BOOL,   TAG_W'(9), ~VAL_W'(1));
		send_item(OP_UNUSED, TAG_MAX,   '1);
		send_item(OP_INT,    TAG_W'(10), VAL_W'(10));
		send_item(OP_OPEN,   '0,        '0);
		send_item(OP_ELEM,   '0,        -VAL_W'(7));
		send_item(OP_CLOSE,  '0,        '0);
		send_item(OP_CLOSE,  '0,        '0);
		send_item(OP_GROUP,  '0,        '0);
		send_item(OP_EMPTY,  '0,        '0);
		send_item(OP_CLOSE,  '0,        '0);

		// No idling; receiver holds off long enough to back up the input
		wait_text_drained(SETTLE_CYCLES);
		write_chars(8'h00, 8'hFF, 8'h00, 8'hFF);
		send_idle = 0;
		stall_pct = 0;
		hold_left = HOLD_CYCLES;
		run_random(items_sent + PHASE_ITEMS);

		// Sparse sender, with a full pause half way
		wait_text_drained(SETTLE_CYCLES);
		write_chars(8'hFF, 8'h00, 8'hFF, 8'h00);
		send_idle = 81;
		stall_pct = 0;
		run_random(items_sent + PHASE_ITEMS / 2);
		wait_text_drained(0);
		run_random(items_sent + PHASE_ITEMS / 2);

		// Heavy receiver stall, random characters
		wait_text_drained(SETTLE_CYCLES);
		write_chars(CHAR_W'($urandom), CHAR_W'($urandom), CHAR_W'($urandom),
			CHAR_W'($urandom));
		send_idle = 0;
		stall_pct = 81;
		run_random(items_sent + PHASE_ITEMS);

		// Light idling on both sides, reset characters written back
		wait_text_drained(SETTLE_CYCLES);
		write_chars(RST_OPEN, RST_CLOSE, RST_YES, RST_NO);
		send_idle = 8;
		stall_pct = 8;
		run_random(items_sent + PHASE_ITEMS);

		wait_text_drained(SETTLE_CYCLES);
		if (board.errors == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

// ----- files.f -----
+incdir+design
design/tvte_pkg.sv
design/tvte_cfg.sv
design/tvte_bcd.sv
design/tag_value_text_encoder.sv
tb/sv/testbench.sv
